>>> design/assert_macros.svh
// assertion macros used by the parser core
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds at every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/dfp_pkg.sv
// types, character codes and a helper function of the decimal field parser
`timescale 1ns / 1ps

package dfp_pkg;

    localparam int CHAR_W    = 8;
    localparam int MANT_W    = 31;
    localparam int FRAC_W    = 4;
    localparam int INDEX_W   = 4;
    localparam int FOUND_W   = 5;
    localparam int MAXF_W    = 5;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = 48;

    localparam logic [MAXF_W-1:0] MAXF_RESET = 5'd3;

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_DOT   = 8'h2E;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'h39;

    typedef struct packed {
        logic              eol;
        logic [CHAR_W-1:0] char_code;
    } t_item;

    typedef struct packed {
        logic               has_value;
        logic [MANT_W-1:0]  value_mantissa;
        logic [FRAC_W-1:0]  fraction_digits;
        logic [INDEX_W-1:0] field_index;
        logic               overflowed;
        logic               end_of_line;
        logic [FOUND_W-1:0] fields_found;
    } t_result;

    // 10^n, evaluated at elaboration for the mantissa bound
    function automatic logic [63:0] pow10(input int n);
        logic [63:0] p;
        p = 64'd1;
        for (int k = 0; k < n; k++) begin
            p = (p << 3) + (p << 1);
        end
        return p;
    endfunction

endpackage

>>> design/dfp_in_stage.sv
// input register of the parser, one item deep
`timescale 1ns / 1ps

module dfp_in_stage
    import dfp_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    input  t_item i_item,
    input  logic  i_take,
    output logic  o_ready,
    output logic  o_valid,
    output t_item o_item
);

    logic  r_valid;
    t_item r_item;

    assign o_ready = !r_valid || i_take;
    assign o_valid = r_valid;
    assign o_item  = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_item <= i_item;
        end
    end

endmodule

>>> design/dfp_core.sv
// field state and per-character parse logic
`timescale 1ns / 1ps

module dfp_core
    import dfp_pkg::*;
#(
    parameter int MANTISSA_DIGITS = 9,
    parameter int FIELD_LIMIT     = 16
)
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_adv,
    input  t_item             i_item,
    input  logic [MAXF_W-1:0] i_max_fields,
    output logic              o_res_valid,
    output t_result           o_res
);

    `include "assert_macros.svh"

    localparam logic [63:0] BOUND64 = pow10(MANTISSA_DIGITS) - 64'd1;
    localparam int ACC_W  = $clog2(pow10(MANTISSA_DIGITS));
    localparam int PROD_W = ACC_W + 4;
    localparam int CNT_W  = $clog2(FIELD_LIMIT + 1);
    localparam int CMP_W  = CNT_W + MAXF_W;
    localparam int MW     = (ACC_W > MANT_W) ? ACC_W : MANT_W;
    localparam logic [ACC_W-1:0]  BOUND = BOUND64[ACC_W-1:0];
    localparam logic [FRAC_W-1:0] FCAP  =
        (MANTISSA_DIGITS > 15) ? 4'd15 : FRAC_W'(MANTISSA_DIGITS);

    logic             r_started, n_started;
    logic             r_neg, n_neg;
    logic             r_frac, n_frac;
    logic [ACC_W-1:0] r_acc, n_acc;
    logic [FRAC_W-1:0] r_fcnt, n_fcnt;
    logic             r_sat, n_sat;
    logic [CNT_W-1:0] r_cnt, n_cnt;

    // field values after taking in the current character
    logic              a_neg, a_frac, a_sat;
    logic [ACC_W-1:0]  a_acc;
    logic [FRAC_W-1:0] a_fcnt;

    logic [CMP_W-1:0]   limit, cnt_ext;
    logic               active, absorb_en, close, is_digit, fits;
    logic [3:0]         digit;
    logic [PROD_W-1:0]  prod;
    logic [MW-1:0]      mag, signed_val;
    logic [CNT_W-1:0]   cnt_inc, cnt_after;
    logic [CNT_W+4:0]   idx_ext, found_ext;

    always_comb begin
        limit   = (CMP_W'(i_max_fields) > CMP_W'(FIELD_LIMIT)) ?
                  CMP_W'(FIELD_LIMIT) : CMP_W'(i_max_fields);
        cnt_ext = CMP_W'(r_cnt);
        active  = cnt_ext < limit;

        absorb_en = active && r_started && (i_item.char_code != CHAR_SPACE);
        close     = active && r_started &&
                    ((i_item.char_code == CHAR_SPACE) || i_item.eol);

        is_digit = i_item.char_code inside {[CHAR_ZERO:CHAR_NINE]};
        digit    = 4'(i_item.char_code - CHAR_ZERO);
        // times ten as two shifts and an add
        prod     = PROD_W'({r_acc, 3'b000}) + PROD_W'({r_acc, 1'b0}) + PROD_W'(digit);
        fits     = prod <= PROD_W'(BOUND);

        a_neg  = r_neg;
        a_frac = r_frac;
        a_acc  = r_acc;
        a_fcnt = r_fcnt;
        a_sat  = r_sat;
        if (absorb_en) begin
            if (i_item.char_code == CHAR_MINUS) begin
                a_neg = 1'b1;
            end else if (i_item.char_code == CHAR_DOT) begin
                a_frac = 1'b1;
            end else if (is_digit) begin
                if (!r_frac) begin
                    if (fits) begin
                        a_acc = prod[ACC_W-1:0];
                    end else begin
                        a_acc = BOUND;
                        a_sat = 1'b1;
                    end
                end else if (fits && (r_fcnt < FCAP)) begin
                    a_acc  = prod[ACC_W-1:0];
                    a_fcnt = r_fcnt + 1'b1;
                end
            end
        end

        cnt_inc   = r_cnt + 1'b1;
        cnt_after = close ? cnt_inc : r_cnt;

        n_started = r_started;
        if (active && !r_started && (i_item.char_code == CHAR_COLON)) begin
            n_started = 1'b1;
        end
        n_neg  = a_neg;
        n_frac = a_frac;
        n_acc  = a_acc;
        n_fcnt = a_fcnt;
        n_sat  = a_sat;
        n_cnt  = cnt_after;
        if (close || i_item.eol) begin
            n_neg  = 1'b0;
            n_frac = 1'b0;
            n_acc  = '0;
            n_fcnt = '0;
            n_sat  = 1'b0;
        end
        if (i_item.eol) begin
            n_started = 1'b0;
            n_cnt     = '0;
        end

        mag        = MW'(a_acc);
        signed_val = a_neg ? (~mag + 1'b1) : mag;
        idx_ext    = (CNT_W + 5)'(r_cnt);
        found_ext  = (CNT_W + 5)'(cnt_after);

        o_res_valid          = close || i_item.eol;
        o_res.has_value      = close;
        o_res.value_mantissa = close ? signed_val[MANT_W-1:0] : '0;
        o_res.fraction_digits = close ? a_fcnt : '0;
        o_res.field_index    = close ? idx_ext[INDEX_W-1:0] : '0;
        o_res.overflowed     = close && a_sat;
        o_res.end_of_line    = i_item.eol;
        o_res.fields_found   = found_ext[FOUND_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_neg     <= 1'b0;
            r_frac    <= 1'b0;
            r_acc     <= '0;
            r_fcnt    <= '0;
            r_sat     <= 1'b0;
            r_cnt     <= '0;
        end else if (i_adv) begin
            r_started <= n_started;
            r_neg     <= n_neg;
            r_frac    <= n_frac;
            r_acc     <= n_acc;
            r_fcnt    <= n_fcnt;
            r_sat     <= n_sat;
            r_cnt     <= n_cnt;
        end
    end

    `ASSERT_ALWAYS(a_cnt_in_range, i_clk, i_rst_n, CMP_W'(r_cnt) <= CMP_W'(FIELD_LIMIT), "field count past limit")
    `ASSERT_ALWAYS(a_acc_in_bound, i_clk, i_rst_n, r_acc <= BOUND, "mantissa past bound")
    `ASSERT_IMPLY(a_empty_is_eol, i_clk, i_rst_n, o_res_valid && !o_res.has_value, o_res.end_of_line, "empty result off line end")
    `ASSERT_NEXT(a_eol_clears, i_clk, i_rst_n, i_adv && i_item.eol, (r_cnt == '0) && !r_started && (r_acc == '0), "line end left state")

endmodule

>>> design/dfp_out_stage.sv
// result register of the parser, drives the master side
`timescale 1ns / 1ps

module dfp_out_stage
    import dfp_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_res,
    input  logic    i_ready,
    output logic    o_space,
    output logic    o_valid,
    output t_result o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_space = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_space) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_space && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

>>> design/decimal_field_parser.sv
// top level of the decimal field parser
//
//  channel  | direction | tdata / data                 | tlast        | tuser
//  ---------+-----------+------------------------------+--------------+----------
//  s_*      | in        | char_code                    | line_end     | -
//  m_*      | out       | mantissa..fields_found       | end_of_line  | has_value
//  cfg_*    | in        | max_fields (5 bit)           | -            | -
//
// one item per cycle sustained while the master side takes results; an item is held in the
// input register until the output register has room, and its result is then loaded there;
// the per-character update (times ten, add, bound compare) sits between the two registers
// synchronous active-low reset clears all field state and sets max_fields to 3
// a stalled master side holds the result; the input register still takes an item
// and stalls only once both registers are full
`timescale 1ns / 1ps

module decimal_field_parser
    import dfp_pkg::*;
#(
    parameter int MANTISSA_DIGITS = 9,
    parameter int FIELD_LIMIT     = 16
)
(
    input  logic                i_clk,
    input  logic                i_rst_n,
    // slave side: tdata = char_code[7:0]
    input  logic                i_s_tvalid,
    output logic                o_s_tready,
    input  logic [S_DATA_W-1:0] i_s_tdata,
    input  logic                i_s_tlast,
    // master side: tdata = value_mantissa[30:0], fraction_digits[34:31],
    // field_index[38:35], overflowed[39], fields_found[44:40], zero[47:45]
    output logic                o_m_tvalid,
    input  logic                i_m_tready,
    output logic [M_DATA_W-1:0] o_m_tdata,
    output logic                o_m_tlast,
    // tuser = has_value
    output logic                o_m_tuser,
    // configuration write, max_fields
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [MAXF_W-1:0]   i_cfg_data
);

    logic [MAXF_W-1:0] r_max_fields;

    t_item   s_item, in_item;
    t_result core_res, out_res;
    logic    in_valid, core_res_valid, out_space, adv;

    // config register, always writable
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_fields <= MAXF_RESET;
        end else if (i_cfg_valid) begin
            r_max_fields <= i_cfg_data;
        end
    end

    assign s_item.char_code = i_s_tdata[CHAR_W-1:0];
    assign s_item.eol       = i_s_tlast;

    // held item moves on when the result register has room
    assign adv = in_valid && out_space;

    dfp_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_tvalid),
        .i_item  (s_item),
        .i_take  (adv),
        .o_ready (o_s_tready),
        .o_valid (in_valid),
        .o_item  (in_item)
    );

    dfp_core #(
        .MANTISSA_DIGITS (MANTISSA_DIGITS),
        .FIELD_LIMIT     (FIELD_LIMIT)
    ) u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_adv        (adv),
        .i_item       (in_item),
        .i_max_fields (r_max_fields),
        .o_res_valid  (core_res_valid),
        .o_res        (core_res)
    );

    // characters that close no field and end no line leave no result
    dfp_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (adv && core_res_valid),
        .i_res   (core_res),
        .i_ready (i_m_tready),
        .o_space (out_space),
        .o_valid (o_m_tvalid),
        .o_res   (out_res)
    );

    assign o_m_tdata = {3'b000,
                        out_res.fields_found,
                        out_res.overflowed,
                        out_res.field_index,
                        out_res.fraction_digits,
                        out_res.value_mantissa};
    assign o_m_tlast = out_res.end_of_line;
    assign o_m_tuser = out_res.has_value;

endmodule
